FILE: design/mf3_pkg.sv
package mf3_pkg;

  typedef struct packed {
    logic [7:0] pixel_ch2;
    logic [7:0] pixel_ch1;
    logic [7:0] pixel_ch0;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_ch0;
    logic [7:0]  out_ch1;
    logic [7:0]  out_ch2;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        run_last;
    logic        frame_done;
  } pix_out_t;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;

  // Window column that a pass-through result is taken from
  localparam logic [1:0] SRC_CENTER = 2'd1;
  localparam logic [1:0] SRC_RIGHT  = 2'd2;

  // Per-slot descriptor handed from front to back
  typedef struct packed {
    logic        vld;
    logic        med;
    logic [1:0]  src;       // window column: 0 left, 1 center, 2 right
    logic        wrow;      // 0 middle window row, 1 bottom window row
    logic [11:0] row;
    logic [9:0]  col;
    logic        fd;
  } slot_t;

  // One front transaction: window snapshot and up to four result slots
  typedef struct packed {
    logic [8:0][23:0] win;
    slot_t [3:0]      slot;
  } job_t;

  localparam int unsigned JOB_W = $bits(job_t);

  function automatic logic [7:0] med9(input logic [8:0][7:0] v);
    logic [7:0] a [9];
    logic [7:0] t;
    for (int i = 0; i < 9; i++) a[i] = v[i];
    // Odd-even transposition over nine values: nine passes
    for (int p = 0; p < 9; p++) begin
      for (int i = (p % 2); i < 8; i += 2) begin
        if (a[i] > a[i+1]) begin
          t = a[i]; a[i] = a[i+1]; a[i+1] = t;
        end
      end
    end
    return a[4];
  endfunction

endpackage

FILE: design/mf3_front.sv
module mf3_front import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  output logic        job_valid_o,
  input  logic        job_full_i,
  output job_t        job_o
);
  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);

  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;
  logic [CW-1:0] col_q, col_d, c;
  logic [RW-1:0] row_q, row_d, r;
  logic [8:0][23:0] win_q, win_d;
  logic [23:0] up_rd, mid_rd;
  logic [23:0] up_mem_q, mid_mem_q;
  logic [23:0] fwd_up_q, fwd_mid_q;
  logic fwd_q, fwd_d;
  logic [23:0] mem_up  [MAX_WIDTH];
  logic [23:0] mem_mid [MAX_WIDTH];
  logic [AW-1:0] ci, ra;
  logic acc;
  logic cfg_hit;
  slot_t [3:0] sl;
  logic [2:0] n;

  // Clamp configuration
  always_comb begin
    if (width_q == '0) w_eff = CW'(1);
    else if ({21'd0, width_q} > 32'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(width_q);
    if (height_q == '0) h_eff = RW'(1);
    else if ({19'd0, height_q} > 32'(MAX_HEIGHT)) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(height_q);
  end

  assign cfg_hit    = cfg_we_i && (cfg_idx_i inside {CFG_WIDTH, CFG_HEIGHT});
  assign in_stall_o = job_full_i;
  assign acc = in_valid_i && !job_full_i;

  always_comb begin
    c  = (col_q >= w_eff) ? w_eff - CW'(1) : col_q;
    r  = (row_q >= h_eff) ? h_eff - RW'(1) : row_q;
    ci = AW'(c);
  end

  // Read the line stores one transaction ahead; forward a same-column write
  always_comb begin
    if (cfg_hit) ra = '0;
    else if (acc) ra = AW'(col_d);
    else ra = ci;
    fwd_d = acc && (ra == ci);
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      mem_up[ci]  <= mid_rd;
      mem_mid[ci] <= in_data_i;
    end
    up_mem_q  <= mem_up[ra];
    mid_mem_q <= mem_mid[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q     <= 1'b0;
      fwd_up_q  <= '0;
      fwd_mid_q <= '0;
    end else begin
      fwd_q <= fwd_d;
      if (acc) begin
        fwd_up_q  <= mid_rd;
        fwd_mid_q <= in_data_i;
      end
    end
  end

  assign up_rd  = fwd_q ? fwd_up_q : up_mem_q;
  assign mid_rd = fwd_q ? fwd_mid_q : mid_mem_q;

  // Shift the window
  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[3*i]   = win_q[3*i+1];
      win_d[3*i+1] = win_q[3*i+2];
    end
    win_d[2] = up_rd;
    win_d[5] = mid_rd;
    win_d[8] = in_data_i;
  end

  // Classify results of this transaction
  always_comb begin
    logic [RW-1:0] orow;
    logic          ok;
    logic [CW-1:0] oc;
    sl = '0;
    n  = '0;
    for (int k = 0; k < 2; k++) begin
      ok   = (k == 0) ? (r >= RW'(1)) : (r == h_eff - RW'(1));
      orow = (k == 0) ? r - RW'(1) : r;
      oc   = c - CW'(1);
      if (ok && c >= CW'(1)) begin
        sl[n[1:0]].vld  = 1'b1;
        sl[n[1:0]].med  = (orow >= RW'(1))
                          && ({1'b0, orow} + (RW+1)'(2) <= {1'b0, h_eff})
                          && (oc >= CW'(1))
                          && ({1'b0, oc} + (CW+1)'(2) <= {1'b0, w_eff});
        sl[n[1:0]].src  = SRC_CENTER;
        sl[n[1:0]].wrow = 1'(k);
        sl[n[1:0]].row  = 12'(orow);
        sl[n[1:0]].col  = 10'(oc);
        n = n + 3'd1;
      end
      if (ok && c == w_eff - CW'(1)) begin
        sl[n[1:0]].vld  = 1'b1;
        sl[n[1:0]].src  = SRC_RIGHT;
        sl[n[1:0]].wrow = 1'(k);
        sl[n[1:0]].row  = 12'(orow);
        sl[n[1:0]].col  = 10'(w_eff - CW'(1));
        sl[n[1:0]].fd   = (orow == h_eff - RW'(1));
        n = n + 3'd1;
      end
    end
  end

  // Advance counters
  always_comb begin
    if (c + CW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (r + RW'(1) >= h_eff) ? '0 : r + RW'(1);
    end else begin
      col_d = c + CW'(1);
      row_d = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
      col_q    <= '0;
      row_q    <= '0;
      win_q    <= '0;
    end else begin
      if (cfg_hit) begin
        if (cfg_idx_i == CFG_WIDTH) width_q <= cfg_data_i[10:0];
        else height_q <= cfg_data_i;
        col_q <= '0;
        row_q <= '0;
      end else if (acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (acc) win_q <= win_d;
    end
  end

  assign job_valid_o = acc && (n != 3'd0);
  assign job_o.win   = win_d;
  assign job_o.slot  = sl;
endmodule

FILE: design/mf3_queue.sv
module mf3_queue import mf3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t din_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t dout_o
);
  job_t mem_q [4];
  logic [2:0] wp_q, rp_q;

  assign empty_o = (wp_q == rp_q);
  // Full when all four entries hold a transaction
  assign full_o  = (wp_q[1:0] == rp_q[1:0]) && (wp_q[2] != rp_q[2]);
  assign dout_o  = mem_q[rp_q[1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q[1:0]] <= din_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 3'd1;
      if (pop_i)  rp_q <= rp_q + 3'd1;
    end
  end
endmodule

FILE: design/mf3_back.sv
module mf3_back import mf3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     job_empty_i,
  input  job_t     job_i,
  output logic     job_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pix_out_t out_data_o
);
  logic [1:0] idx_q, idx_d;
  logic [23:0] med_q, med_d;
  logic med_ok_q;
  slot_t s;
  logic [23:0] px;
  logic last;
  logic load;
  pix_out_t obuf_q;
  logic ovld_q;
  logic [8:0][7:0] v0, v1, v2;

  // Median of the window, computed once per job and registered
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v0[i] = job_i.win[i][7:0];
      v1[i] = job_i.win[i][15:8];
      v2[i] = job_i.win[i][23:16];
    end
    med_d = {med9(v2), med9(v1), med9(v0)};
  end

  always_comb begin
    s    = job_i.slot[idx_q];
    case (s.src)
      SRC_CENTER: px = s.wrow ? job_i.win[7] : job_i.win[4];
      SRC_RIGHT:  px = s.wrow ? job_i.win[8] : job_i.win[5];
      default:    px = job_i.win[3];
    endcase
    if (s.med) px = med_q;
    last = (idx_q == 2'd3) || !job_i.slot[idx_q + 2'd1].vld;
  end

  // Emit one slot per cycle once the median is ready and the output is not stalled
  assign load      = !job_empty_i && med_ok_q && (!ovld_q || !out_stall_i);
  assign job_pop_o = load && last;
  assign idx_d     = job_pop_o ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      med_ok_q <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      if (load) idx_q <= idx_d;
      med_ok_q <= !job_empty_i && !job_pop_o;
      if (load) ovld_q <= 1'b1;
      else if (!out_stall_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q <= med_d;
    if (load) begin
      obuf_q.out_ch0    <= px[7:0];
      obuf_q.out_ch1    <= px[15:8];
      obuf_q.out_ch2    <= px[23:16];
      obuf_q.out_row    <= s.row;
      obuf_q.out_col    <= s.col;
      obuf_q.run_last   <= last;
      obuf_q.frame_done <= s.fd;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_data_o  = obuf_q;
endmodule

FILE: design/median3x3_rgb_filter.sv
// 3x3 per-channel median filter for a raster-order RGB pixel stream.
// Input channel: in_valid_i / in_stall_o with in_data_i (one pixel).
// Output channel: out_valid_o / out_stall_i with out_data_o; each result
// carries its row and column, run_last on the final result of an input
// pixel, and frame_done on pixel (H-1, W-1).
// Interior pixels get the median of their neighborhood; borders pass through.
// Output row r-1 appears while row r streams in; the last pixel of a frame
// produces four results.
// Throughput: pixels without results (first row and first column of a frame)
// enter one per cycle while the job queue is not full; a pixel with results
// holds the back end while its median is registered and then while each of
// its results is emitted, so a steady stream with results is limited by the
// back end and the four-entry job queue then stalls the input. A result
// passes the job queue, the median register and the output register.
// Configuration: cfg_we_i with cfg_idx_i (0 width, 1 height, others ignored)
// and cfg_data_i, written while idle; a write restarts the frame at (0,0).
// Reset clears counters, window and queue; line stores are not cleared.
// When the receiver stalls, the output holds and the queue fills, then the
// input stalls.
module median3x3_rgb_filter import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pix_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pix_out_t    out_data_o
);
  logic job_valid, job_full, job_empty, job_pop;
  job_t job_in, job_out;

  mf3_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_full_i(job_full), .job_o(job_in)
  );

  mf3_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_valid), .din_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .empty_o(job_empty), .dout_o(job_out)
  );

  mf3_back u_back (
    .clk_i, .rst_ni, .job_empty_i(job_empty), .job_i(job_out), .job_pop_o(job_pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );
endmodule
